/* hdl/drlg_pkg.sv */
// Shared types and constants of the delayed linear ramp generator.
package drlg_pkg;

    localparam int TIME_BITS   = 32;
    localparam int VALUE_W     = 32;
    localparam int DELAY_W     = 24;
    localparam int LIMIT_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] STYLE_ANY     = 2'd0;
    localparam logic [1:0] STYLE_RISING  = 2'd1;
    localparam logic [1:0] STYLE_FALLING = 2'd2;

    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_KEEP    = 2'd1;
    localparam logic [1:0] MODE_STRETCH = 2'd2;

    localparam logic [1:0] CFG_DELAY_MODE         = 2'd0;
    localparam logic [1:0] CFG_STRETCH_FRACTION   = 2'd1;
    localparam logic [1:0] CFG_MAX_DELAY_MULTIPLE = 2'd2;

    localparam logic [1:0] DELAY_MODE_RESET         = MODE_STRETCH;
    localparam logic [7:0] STRETCH_FRACTION_RESET   = 8'd85;
    localparam logic [7:0] MAX_DELAY_MULTIPLE_RESET = 8'd4;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_RETARGET = 1'b1
    } op_t;

    typedef struct packed {
        logic [1:0] delay_mode;
        logic [7:0] stretch_fraction;
        logic [7:0] max_delay_multiple;
    } cfg_t;

    typedef struct packed {
        op_t                       op;
        logic [TIME_BITS-1:0]      now;
        logic signed [VALUE_W-1:0] target;
        logic [TIME_BITS-1:0]      length;
        logic [1:0]                style;
        logic [TIME_BITS-1:0]      plain;
        logic [DELAY_W-1:0]        stretch;
        logic [LIMIT_W-1:0]        limit;
    } cmd_t;

endpackage

/* hdl/drlg_front.sv */
// Front end: accepts input transactions and prepares retiming terms for the back end.
module drlg_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  drlg_pkg::cfg_t                      cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [31:0]                         s_now_ms,
    input  logic signed [31:0]                  s_new_target,
    input  logic [31:0]                         s_ramp_length,
    input  logic [1:0]                          s_ramp_style,
    input  logic [23:0]                         s_start_delay,
    output logic                                push_valid,
    input  logic                                push_ready,
    output drlg_pkg::cmd_t                      push_cmd
);

    logic                                 f_valid_reg;
    drlg_pkg::op_t                        op_reg;
    logic [drlg_pkg::TIME_BITS-1:0]       now_reg;
    logic signed [drlg_pkg::VALUE_W-1:0]  target_reg;
    logic [drlg_pkg::TIME_BITS-1:0]       length_reg;
    logic [1:0]                           style_reg;
    logic [drlg_pkg::DELAY_W-1:0]         delay_reg;

    logic [31:0] plain_sum;
    logic [31:0] stretch_prod;
    logic [31:0] limit_prod;

    assign s_ready    = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg     <= drlg_pkg::op_t'(s_operation);
            now_reg    <= s_now_ms[drlg_pkg::TIME_BITS-1:0];
            target_reg <= s_new_target;
            length_reg <= s_ramp_length[drlg_pkg::TIME_BITS-1:0];
            style_reg  <= s_ramp_style;
            delay_reg  <= s_start_delay;
        end
    end

    always_comb begin
        plain_sum    = 32'(delay_reg) + 32'(now_reg);
        stretch_prod = 32'(delay_reg) * 32'(cfg.stretch_fraction);
        limit_prod   = 32'(delay_reg) * 32'(cfg.max_delay_multiple);

        push_cmd.op      = op_reg;
        push_cmd.now     = now_reg;
        push_cmd.target  = target_reg;
        push_cmd.length  = length_reg;
        push_cmd.style   = style_reg;
        push_cmd.plain   = plain_sum[drlg_pkg::TIME_BITS-1:0];
        push_cmd.stretch = stretch_prod[31:8];
        push_cmd.limit   = limit_prod;
    end

endmodule

/* hdl/drlg_queue.sv */
// Short command queue between the front end and the back end.
module drlg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  drlg_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output drlg_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(drlg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(drlg_pkg::QUEUE_DEPTH + 1);

    drlg_pkg::cmd_t   mem_reg [drlg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = count_reg != CNT_W'(drlg_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                if (wr_ptr_reg == PTR_W'(drlg_pkg::QUEUE_DEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (pop_fire) begin
                if (rd_ptr_reg == PTR_W'(drlg_pkg::QUEUE_DEPTH - 1)) begin
                    rd_ptr_reg <= '0;
                end else begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/drlg_muldiv.sv */
// Serial unit that forms floor(mag * elapsed / length) one multiplier bit per cycle.
module drlg_muldiv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [drlg_pkg::VALUE_W-1:0]   mag,
    input  logic [drlg_pkg::TIME_BITS-1:0] elapsed,
    input  logic [drlg_pkg::TIME_BITS-1:0] length,
    output logic                           done,
    output logic [drlg_pkg::VALUE_W-1:0]   quot
);

    localparam int VW    = drlg_pkg::VALUE_W;
    localparam int TW    = drlg_pkg::TIME_BITS;
    localparam int CNT_W = $clog2(VW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    mag_reg;
    logic [VW-1:0]    q_reg;
    logic [TW-1:0]    r_reg;
    logic [TW-1:0]    e_reg;
    logic [TW-1:0]    l_reg;

    logic [TW+1:0] t_sum;
    logic [TW+1:0] l_one;
    logic [TW+1:0] l_two;
    logic [TW+1:0] t_rem;
    logic [1:0]    digit;
    logic [TW-1:0] r_next;
    logic [VW-1:0] q_next;

    assign done = done_reg;
    assign quot = q_reg;

    always_comb begin
        l_one = (TW+2)'(l_reg);
        l_two = (TW+2)'({l_reg, 1'b0});
        t_sum = (TW+2)'({r_reg, 1'b0}) + (mag_reg[VW-1] ? (TW+2)'(e_reg) : '0);
        if (t_sum >= l_two) begin
            t_rem = t_sum - l_two;
            digit = 2'd2;
        end else if (t_sum >= l_one) begin
            t_rem = t_sum - l_one;
            digit = 2'd1;
        end else begin
            t_rem = t_sum;
            digit = 2'd0;
        end
        r_next = t_rem[TW-1:0];
        q_next = {q_reg[VW-2:0], 1'b0} + VW'(digit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(VW - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
        if (start) begin
            mag_reg <= mag;
            e_reg   <= elapsed;
            l_reg   <= length;
            q_reg   <= '0;
            r_reg   <= '0;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[VW-2:0], 1'b0};
            q_reg   <= q_next;
            r_reg   <= r_next;
        end
    end

endmodule

/* hdl/drlg_back.sv */
// Back end: ramp state, retiming of retargets, tick evaluation and the result register.
module drlg_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  drlg_pkg::cfg_t             cfg,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  drlg_pkg::cmd_t             pop_cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_current_value,
    output logic                       m_ramp_done
);

    localparam int VW = drlg_pkg::VALUE_W;
    localparam int TW = drlg_pkg::TIME_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RT_BEGIN,
        ST_RT_CLAMP,
        ST_RT_FINISH,
        ST_TK_CHECK,
        ST_TK_SPAN,
        ST_TK_START,
        ST_TK_DIV,
        ST_OUT
    } state_t;

    state_t                state_reg;
    drlg_pkg::cmd_t        cmd_reg;
    logic signed [VW-1:0]  out_value_reg;
    logic signed [VW-1:0]  from_value_reg;
    logic signed [VW-1:0]  goal_value_reg;
    logic [TW-1:0]         begin_time_reg;
    logic [TW-1:0]         finish_time_reg;
    logic [1:0]            style_reg;
    logic                  finished_reg;
    logic [TW-1:0]         len_reg;
    logic [TW-1:0]         el_reg;
    logic [VW-1:0]         mag_reg;
    logic                  neg_reg;
    logic                  m_valid_reg;
    logic signed [VW-1:0]  m_value_reg;
    logic                  m_done_reg;

    logic                  rising;
    logic                  change;
    logic                  begin_past;
    logic [31:0]           stretch_sum;
    logic [31:0]           clamp_sum;
    logic [TW-1:0]         pending;
    logic                  wrong_dir;
    logic                  md_start;
    logic                  md_done;
    logic [VW-1:0]         md_quot;

    assign pop_ready       = state_reg == ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_current_value = m_value_reg;
    assign m_ramp_done     = m_done_reg;
    assign md_start        = (state_reg == ST_TK_START) && (len_reg != '0);

    always_comb begin
        rising      = $signed(cmd_reg.target) > goal_value_reg;
        change      = (style_reg != cmd_reg.style) ||
                      (rising == (cmd_reg.style != drlg_pkg::STYLE_FALLING));
        begin_past  = begin_time_reg < cmd_reg.now;
        stretch_sum = 32'(begin_time_reg) + 32'(cmd_reg.stretch);
        clamp_sum   = cmd_reg.limit + 32'(cmd_reg.now);
        pending     = begin_time_reg - cmd_reg.now;
        wrong_dir   = (goal_value_reg < from_value_reg &&
                       style_reg == drlg_pkg::STYLE_RISING) ||
                      (goal_value_reg > from_value_reg &&
                       style_reg == drlg_pkg::STYLE_FALLING);
    end

    drlg_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .mag     (mag_reg),
        .elapsed (el_reg),
        .length  (len_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            out_value_reg   <= '0;
            from_value_reg  <= '0;
            goal_value_reg  <= '0;
            begin_time_reg  <= '0;
            finish_time_reg <= '1;
            style_reg       <= drlg_pkg::STYLE_ANY;
            finished_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        cmd_reg <= pop_cmd;
                        if (pop_cmd.op == drlg_pkg::OP_RETARGET) begin
                            state_reg <= ST_RT_BEGIN;
                        end else begin
                            state_reg <= ST_TK_CHECK;
                        end
                    end
                end
                ST_RT_BEGIN: begin
                    case (cfg.delay_mode)
                        drlg_pkg::MODE_KEEP: begin
                            if (finished_reg) begin
                                begin_time_reg <= cmd_reg.plain;
                            end else if (begin_past) begin
                                begin_time_reg <= cmd_reg.now;
                            end
                            state_reg <= ST_RT_FINISH;
                        end
                        drlg_pkg::MODE_STRETCH: begin
                            if (finished_reg) begin
                                begin_time_reg <= cmd_reg.plain;
                                state_reg      <= ST_RT_FINISH;
                            end else begin
                                if (change) begin
                                    begin_time_reg <= stretch_sum[TW-1:0];
                                end else if (begin_past) begin
                                    begin_time_reg <= cmd_reg.now;
                                end
                                state_reg <= ST_RT_CLAMP;
                            end
                        end
                        default: begin
                            begin_time_reg <= cmd_reg.plain;
                            state_reg      <= ST_RT_FINISH;
                        end
                    endcase
                end
                ST_RT_CLAMP: begin
                    if (32'(pending) > cmd_reg.limit) begin
                        begin_time_reg <= clamp_sum[TW-1:0];
                    end
                    state_reg <= ST_RT_FINISH;
                end
                ST_RT_FINISH: begin
                    goal_value_reg  <= $signed(cmd_reg.target);
                    finish_time_reg <= begin_time_reg + cmd_reg.length;
                    style_reg       <= cmd_reg.style;
                    from_value_reg  <= out_value_reg;
                    finished_reg    <= 1'b0;
                    state_reg       <= ST_OUT;
                end
                ST_TK_CHECK: begin
                    if (finished_reg) begin
                        out_value_reg <= goal_value_reg;
                        state_reg     <= ST_OUT;
                    end else if (wrong_dir) begin
                        finished_reg  <= 1'b1;
                        out_value_reg <= goal_value_reg;
                        state_reg     <= ST_OUT;
                    end else if (cmd_reg.now < begin_time_reg) begin
                        state_reg <= ST_OUT;
                    end else if (cmd_reg.now > finish_time_reg) begin
                        out_value_reg  <= goal_value_reg;
                        from_value_reg <= goal_value_reg;
                        finished_reg   <= 1'b1;
                        state_reg      <= ST_OUT;
                    end else begin
                        state_reg <= ST_TK_SPAN;
                    end
                end
                ST_TK_SPAN: begin
                    len_reg <= finish_time_reg - begin_time_reg;
                    el_reg  <= cmd_reg.now - begin_time_reg;
                    neg_reg <= goal_value_reg < from_value_reg;
                    if (goal_value_reg < from_value_reg) begin
                        mag_reg <= from_value_reg - goal_value_reg;
                    end else begin
                        mag_reg <= goal_value_reg - from_value_reg;
                    end
                    state_reg <= ST_TK_START;
                end
                ST_TK_START: begin
                    if (len_reg == '0) begin
                        out_value_reg  <= goal_value_reg;
                        from_value_reg <= goal_value_reg;
                        finished_reg   <= 1'b1;
                        state_reg      <= ST_OUT;
                    end else begin
                        state_reg <= ST_TK_DIV;
                    end
                end
                ST_TK_DIV: begin
                    if (md_done) begin
                        if (neg_reg) begin
                            out_value_reg <= from_value_reg - $signed(md_quot);
                        end else begin
                            out_value_reg <= from_value_reg + $signed(md_quot);
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= out_value_reg;
                        m_done_reg  <= finished_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/delayed_linear_ramp_generator_core.sv */
// Top level of the delayed linear ramp generator with its configuration registers.
// An interpolating tick spends most of its time in the 32-step serial multiply-divide;
// retargets and ticks that do not interpolate skip it.
// The back end handles one transaction at a time, and a two-entry queue buffers the
// front end.
// Reset is synchronous and active low; it restores the register defaults and clears the ramp.
module delayed_linear_ramp_generator_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [31:0]        s_now_ms,
    input  logic signed [31:0] s_new_target,
    input  logic [31:0]        s_ramp_length,
    input  logic [1:0]         s_ramp_style,
    input  logic [23:0]        s_start_delay,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_current_value,
    output logic               m_ramp_done
);

    drlg_pkg::cfg_t cfg_reg;
    logic           push_valid;
    logic           push_ready;
    drlg_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    drlg_pkg::cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_mode         <= drlg_pkg::DELAY_MODE_RESET;
            cfg_reg.stretch_fraction   <= drlg_pkg::STRETCH_FRACTION_RESET;
            cfg_reg.max_delay_multiple <= drlg_pkg::MAX_DELAY_MULTIPLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                drlg_pkg::CFG_DELAY_MODE: begin
                    cfg_reg.delay_mode <= cfg_data[1:0];
                end
                drlg_pkg::CFG_STRETCH_FRACTION: begin
                    cfg_reg.stretch_fraction <= cfg_data;
                end
                drlg_pkg::CFG_MAX_DELAY_MULTIPLE: begin
                    cfg_reg.max_delay_multiple <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    drlg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_now_ms      (s_now_ms),
        .s_new_target  (s_new_target),
        .s_ramp_length (s_ramp_length),
        .s_ramp_style  (s_ramp_style),
        .s_start_delay (s_start_delay),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    drlg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    drlg_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_value (m_current_value),
        .m_ramp_done     (m_ramp_done)
    );

endmodule

/* hdl/drlg_checker.sv */
// Port-level checker of the delayed linear ramp generator and its bind statement.
module drlg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_current_value,
    input logic        m_ramp_done
);

    localparam logic [2:0] MAX_PENDING = 3'd5;

    logic [2:0] pending_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (s_fire && !m_fire) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A result held back by the consumer keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_value) && $stable(m_ramp_done))
        else $error("stalled result changed");

    // Every result answers an input transaction that was taken earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding transaction");

    // The pipeline holds no more transactions than its stages and queue can store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= MAX_PENDING)
        else $error("too many outstanding transactions");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reset leaves the input side open.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind delayed_linear_ramp_generator_core drlg_checker u_drlg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_current_value (m_current_value),
    .m_ramp_done     (m_ramp_done)
);
